>>> src/agtp_pkg.sv
// ---------------------------------------------------------------------------
// agtp_pkg: shared types and constants
// Fixed field widths, gain constants, codes and the controller/datapath
// command and status structs of the adaptive gain tilt PID block.
// ---------------------------------------------------------------------------
package agtp_pkg;

	// Fixed field and register widths
	localparam int KI_W       = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int INT_W      = 20;
	localparam int RUN_W      = 5;
	localparam int KP_W       = 13;
	localparam int KD_W       = 12;
	localparam int GAIN_W     = 17;
	localparam int DIR_W      = 2;
	localparam int DUTY_W     = 7;
	localparam int PH_W       = 8;
	localparam int PL_W       = 10;
	localparam int OUT_DATA_W = 32;

	// Divider sizing: 384000 / (800 - m)
	localparam int DIVIDEND_W = 19;
	localparam int DIVISOR_W  = 10;
	localparam int DIV_CNT_W  = 5;
	localparam int DIV_STEPS  = 19;

	// Proportional gain, Q5.8
	localparam int KP_NUM      = 384000;
	localparam int M_MAX       = 799;
	localparam int KP_DEN_BASE = 800;
	localparam int KP_OFFSET   = 896;
	localparam int KP_MIN      = 512;
	localparam int KP_MAX      = 4096;
	localparam int KP_QUO_LO   = KP_MIN + KP_OFFSET;
	localparam int KP_QUO_HI   = KP_MAX + KP_OFFSET;

	// Derivative gain: 8000 - 32*|raw| within 2000..4000
	localparam int KD_BASE    = 8000;
	localparam int KD_MIN     = 2000;
	localparam int KD_MAX     = 4000;
	localparam int KD_RAW_LO  = 125;
	localparam int KD_RAW_HI  = 188;
	localparam int KD_SHIFT   = 5;
	localparam int KD_RAW_W   = 8;

	// Integral clamp, Q.12
	localparam int INT_LIMIT = 409600;

	// Duty: (|sum| >> 12) / 25, saturated at 100
	localparam int SUM_FRAC         = 12;
	localparam int DUTY_Q_SAT       = 2500;
	localparam int DUTY_Q_W         = 12;
	localparam int DUTY_RECIP       = 1311;
	localparam int DUTY_RECIP_SHIFT = 15;
	localparam int DUTY_RECIP_W     = 23;
	localparam int DUTY_MAX         = 100;

	// Pulse timing
	localparam int PULSE_HIGH_DRIVE = 50;
	localparam int PULSE_HIGH_HOLD  = 200;
	localparam int PULSE_LOW_BASE   = 1000;
	localparam int PULSE_LOW_STEP   = 9;

	// Register reset values
	localparam int DB_HIGH_RST = 100;
	localparam int DB_LOW_RST  = -100;

	typedef enum logic [DIR_W-1:0] {
		DIR_NEG   = 2'd0,
		DIR_POS   = 2'd1,
		DIR_BRAKE = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		REG_KI      = 2'd0,
		REG_DB_HIGH = 2'd1,
		REG_DB_LOW  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_ERR_KI = 2'd0,
		MUL_ERR_KP = 2'd1,
		MUL_DR_KD  = 2'd2
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_I,
		ST_INT,
		ST_KP,
		ST_MUL_P,
		ST_ACC1,
		ST_MUL_D,
		ST_ACC2,
		ST_DUTY,
		ST_OUT
	} agtp_state_t;

	typedef struct packed {
		logic     load_in;
		logic     eval_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     int_upd;
		logic     kp_load;
		logic     acc_first;
		logic     acc_second;
		logic     duty_calc;
		logic     out_load;
	} agtp_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic out_free;
	} agtp_status_t;

endpackage

>>> src/adaptive_gain_tilt_pid.sv
// ---------------------------------------------------------------------------
// adaptive_gain_tilt_pid: adaptive gain tilt PID controller
// Left/right height in, direction, duty and pulse times out; APB registers
// for integral gain and deadband edges.
// ---------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_*       in   s_tvalid / s_tready           left_height, right_height
//  m_*       out  m_tvalid / m_tready           direction, duty, pulse times
//  apb       in   psel, penable, pwrite, pready ki, deadband_high, deadband_low
//
//  An item moves from input transfer through the agtp_ctrl states to the output
//  register; the 19-step kp divider takes most of that time.
//  One item is in work at a time; the next input is taken once the previous
//  result sits in the output register, even while m_tready is low.
//  A stalled output holds the next finished item in the last state until the
//  output register frees.
//  Reset clears the derivative history, integral and zero-run count and loads
//  the register defaults (ki 0, deadband edges +100 and -100).
// ---------------------------------------------------------------------------
module adaptive_gain_tilt_pid import agtp_pkg::*; #(
	parameter int HEIGHT_BITS    = 14,
	parameter int ZERO_RUN_LIMIT = 25,
	localparam int IN_DATA_W     = ((2 * HEIGHT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // left_height, right_height, zero pad
	// Output stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // direction, duty, pulse_high_ms,
	                                        // pulse_low_ms, pulsing, zero pad
);

	localparam int PAD_W = OUT_DATA_W - (DIR_W + DUTY_W + PH_W + PL_W + 1);
	localparam int EXT_W = CFG_DATA_W - HEIGHT_BITS;

	logic signed [KI_W-1:0]        ki_q;
	logic signed [HEIGHT_BITS-1:0] db_high_q;
	logic signed [HEIGHT_BITS-1:0] db_low_q;
	logic                          cfg_write;
	reg_idx_t                      cfg_idx;

	agtp_cmd_t                     cmd;
	agtp_status_t                  status;
	logic [DIR_W-1:0]              direction;
	logic [DUTY_W-1:0]             duty;
	logic [PH_W-1:0]               pulse_high_ms;
	logic [PL_W-1:0]               pulse_low_ms;
	logic                          pulsing;

	// Register write on the access cycle
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ki_q      <= '0;
			db_high_q <= HEIGHT_BITS'(DB_HIGH_RST);
			db_low_q  <= HEIGHT_BITS'(DB_LOW_RST);
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_KI:      ki_q      <= pwdata[KI_W-1:0];
				REG_DB_HIGH: db_high_q <= pwdata[HEIGHT_BITS-1:0];
				REG_DB_LOW:  db_low_q  <= pwdata[HEIGHT_BITS-1:0];
				default:     ;
			endcase
		end
	end

	// Read back sign-extended
	always_comb begin
		unique case (cfg_idx)
			REG_KI:      prdata = {{(CFG_DATA_W-KI_W){ki_q[KI_W-1]}}, ki_q};
			REG_DB_HIGH: prdata = {{EXT_W{db_high_q[HEIGHT_BITS-1]}}, db_high_q};
			REG_DB_LOW:  prdata = {{EXT_W{db_low_q[HEIGHT_BITS-1]}}, db_low_q};
			default:     prdata = '0;
		endcase
	end

	agtp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	agtp_datapath #(
		.HEIGHT_BITS    (HEIGHT_BITS),
		.ZERO_RUN_LIMIT (ZERO_RUN_LIMIT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.left_height   (s_tdata[HEIGHT_BITS-1:0]),
		.right_height  (s_tdata[2*HEIGHT_BITS-1:HEIGHT_BITS]),
		.ki            (ki_q),
		.deadband_high (db_high_q),
		.deadband_low  (db_low_q),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.direction     (direction),
		.duty          (duty),
		.pulse_high_ms (pulse_high_ms),
		.pulse_low_ms  (pulse_low_ms),
		.pulsing       (pulsing)
	);

	// Pack the result, first field lowest
	assign m_tdata = {{PAD_W{1'b0}}, pulsing, pulse_low_ms, pulse_high_ms, duty, direction};

endmodule

>>> src/agtp_div.sv
// ---------------------------------------------------------------------------
// agtp_div: iterative restoring divider
// Unsigned divide, one quotient bit per cycle, busy while steps remain.
// ---------------------------------------------------------------------------
module agtp_div import agtp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	// Count remaining steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy     = cnt_q != '0;
	assign quotient = quo_q;

endmodule

>>> src/agtp_datapath.sv
// ---------------------------------------------------------------------------
// agtp_datapath: PID arithmetic
// Error, deadband, adaptive gains, shared multiplier, integral with zero-run
// clear, sum accumulation, duty and pulse formatting, output register.
// ---------------------------------------------------------------------------
module agtp_datapath import agtp_pkg::*; #(
	parameter int HEIGHT_BITS    = 14,
	parameter int ZERO_RUN_LIMIT = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  agtp_cmd_t                     cmd,
	output agtp_status_t                  status,
	input  logic signed [HEIGHT_BITS-1:0] left_height,
	input  logic signed [HEIGHT_BITS-1:0] right_height,
	input  logic signed [KI_W-1:0]        ki,
	input  logic signed [HEIGHT_BITS-1:0] deadband_high,
	input  logic signed [HEIGHT_BITS-1:0] deadband_low,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [DIR_W-1:0]              direction,
	output logic [DUTY_W-1:0]             duty,
	output logic [PH_W-1:0]               pulse_high_ms,
	output logic [PL_W-1:0]               pulse_low_ms,
	output logic                          pulsing
);

	localparam int RAW_W  = HEIGHT_BITS + 1;
	localparam int ERR_W  = HEIGHT_BITS + 2;
	localparam int PROD_W = ERR_W + GAIN_W;
	localparam int ISUM_W = PROD_W + 1;
	localparam int SUM_W  = HEIGHT_BITS + 27;
	localparam int Q_W    = SUM_W - SUM_FRAC;
	localparam int P_EXT  = SUM_W - PROD_W - 4;

	localparam logic signed [ISUM_W-1:0] INT_HI = ISUM_W'(INT_LIMIT);
	localparam logic signed [ISUM_W-1:0] INT_LO = -ISUM_W'(INT_LIMIT);

	logic signed [RAW_W-1:0]  raw_q;
	logic signed [RAW_W-1:0]  prev_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  dr_q;
	logic [KD_W-1:0]          kd_q;
	logic [KP_W-1:0]          kp_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [INT_W-1:0]  integral_q;
	logic [RUN_W-1:0]         run_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic [DUTY_W-1:0]        duty_q;
	dir_t                     dir_q;
	logic                     out_valid_q;
	dir_t                     dir_out_q;
	logic [DUTY_W-1:0]        duty_out_q;
	logic [PH_W-1:0]          ph_q;
	logic [PL_W-1:0]          pl_q;
	logic                     pulsing_q;

	logic signed [ERR_W-1:0]  raw_ext;
	logic signed [ERR_W-1:0]  prev_ext;
	logic signed [ERR_W-1:0]  dbh_ext;
	logic signed [ERR_W-1:0]  dbl_ext;
	logic signed [ERR_W-1:0]  err_next;
	logic [ERR_W-1:0]         abs_err;
	logic [DIVISOR_W-1:0]     m_clip;
	logic [DIVISOR_W-1:0]     kp_den;
	logic [RAW_W-1:0]         abs_raw;
	logic [KP_W:0]            kd_lin;
	logic [KD_W-1:0]          kd_next;
	logic                     div_busy;
	logic [DIVIDEND_W-1:0]    quo;
	logic [KP_W-1:0]          kp_next;
	logic signed [ERR_W-1:0]  mul_a;
	logic signed [GAIN_W-1:0] mul_b;
	logic signed [PROD_W-1:0] prod_next;
	logic signed [ISUM_W-1:0] int_sum;
	logic signed [INT_W-1:0]  int_clamped;
	logic [RUN_W-1:0]         run_inc;
	logic                     err_zero;
	logic                     run_hit;
	logic signed [SUM_W-1:0]  p_term;
	logic signed [SUM_W-1:0]  i_term;
	logic signed [SUM_W-1:0]  d_term;
	logic [SUM_W-1:0]         abs_acc;
	logic [Q_W-1:0]           q_val;
	logic [DUTY_RECIP_W-1:0]  recip;
	logic [DUTY_W-1:0]        duty_next;
	dir_t                     dir_next;

	// Deadband on the raw error; upper edge wins when the edges cross
	assign raw_ext  = {raw_q[RAW_W-1], raw_q};
	assign prev_ext = {prev_q[RAW_W-1], prev_q};
	assign dbh_ext  = {{2{deadband_high[HEIGHT_BITS-1]}}, deadband_high};
	assign dbl_ext  = {{2{deadband_low[HEIGHT_BITS-1]}}, deadband_low};

	always_comb begin
		if (raw_ext > dbh_ext) begin
			err_next = raw_ext - dbh_ext;
		end else if (raw_ext < dbl_ext) begin
			err_next = raw_ext - dbl_ext;
		end else begin
			err_next = '0;
		end
	end

	// Divisor for kp: 800 - min(|err|, 799)
	assign abs_err = err_next[ERR_W-1] ? ERR_W'(-err_next) : ERR_W'(err_next);
	assign m_clip  = (abs_err > ERR_W'(M_MAX)) ? DIVISOR_W'(M_MAX)
	                                           : abs_err[DIVISOR_W-1:0];
	assign kp_den  = DIVISOR_W'(KP_DEN_BASE) - m_clip;

	// Derivative gain from |raw|, linear between the two clamp points
	assign abs_raw = raw_q[RAW_W-1] ? RAW_W'(-raw_q) : RAW_W'(raw_q);
	assign kd_lin  = (KP_W+1)'(KD_BASE)
	               - {1'b0, abs_raw[KD_RAW_W-1:0], KD_SHIFT'(0)};

	always_comb begin
		if (abs_raw <= RAW_W'(KD_RAW_LO)) begin
			kd_next = KD_W'(KD_MAX);
		end else if (abs_raw >= RAW_W'(KD_RAW_HI)) begin
			kd_next = KD_W'(KD_MIN);
		end else begin
			kd_next = kd_lin[KD_W-1:0];
		end
	end

	agtp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.eval_err),
		.dividend (DIVIDEND_W'(KP_NUM)),
		.divisor  (kp_den),
		.busy     (div_busy),
		.quotient (quo)
	);

	// Clamp kp to 2.0..16.0 after removing the 3.5 offset
	always_comb begin
		if (quo >= DIVIDEND_W'(KP_QUO_HI)) begin
			kp_next = KP_W'(KP_MAX);
		end else if (quo <= DIVIDEND_W'(KP_QUO_LO)) begin
			kp_next = KP_W'(KP_MIN);
		end else begin
			kp_next = KP_W'(quo - DIVIDEND_W'(KP_OFFSET));
		end
	end

	// Shared signed multiplier
	assign mul_a = (cmd.mul_sel == MUL_DR_KD) ? dr_q : err_q;

	always_comb begin
		case (cmd.mul_sel)
			MUL_ERR_KI: mul_b = {ki[KI_W-1], ki};
			MUL_ERR_KP: mul_b = {{(GAIN_W-KP_W){1'b0}}, kp_q};
			MUL_DR_KD:  mul_b = {{(GAIN_W-KD_W){1'b0}}, kd_q};
			default:    mul_b = '0;
		endcase
	end

	assign prod_next = mul_a * mul_b;

	// Integral with clamp and zero-run clear
	assign int_sum = {{(ISUM_W-INT_W){integral_q[INT_W-1]}}, integral_q}
	               + {prod_q[PROD_W-1], prod_q};

	always_comb begin
		if (int_sum > INT_HI) begin
			int_clamped = INT_W'(INT_HI);
		end else if (int_sum < INT_LO) begin
			int_clamped = INT_W'(INT_LO);
		end else begin
			int_clamped = int_sum[INT_W-1:0];
		end
	end

	assign err_zero = err_q == '0;
	assign run_inc  = run_q + RUN_W'(1);
	assign run_hit  = err_zero && (run_inc >= RUN_W'(ZERO_RUN_LIMIT));

	// Sum terms, Q.12
	assign p_term = {{P_EXT{prod_q[PROD_W-1]}}, prod_q, 4'b0};
	assign i_term = {{(SUM_W-INT_W){integral_q[INT_W-1]}}, integral_q};
	assign d_term = {prod_q[SUM_W-SUM_FRAC-1:0], SUM_FRAC'(0)};

	// Duty: (|sum| >> 12) / 25 by reciprocal, exact below the saturation point
	assign abs_acc = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
	assign q_val   = abs_acc[SUM_W-1:SUM_FRAC];
	assign recip   = DUTY_RECIP_W'(q_val[DUTY_Q_W-1:0]) * DUTY_RECIP_W'(DUTY_RECIP);

	always_comb begin
		if (q_val >= Q_W'(DUTY_Q_SAT)) begin
			duty_next = DUTY_W'(DUTY_MAX);
		end else begin
			duty_next = recip[DUTY_RECIP_SHIFT+DUTY_W-1:DUTY_RECIP_SHIFT];
		end
		if (acc_q == '0) begin
			dir_next = DIR_BRAKE;
		end else if (acc_q[SUM_W-1]) begin
			dir_next = DIR_NEG;
		end else begin
			dir_next = DIR_POS;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			raw_q <= {left_height[HEIGHT_BITS-1], left_height}
			       - {right_height[HEIGHT_BITS-1], right_height};
		end
		if (cmd.eval_err) begin
			err_q <= err_next;
			dr_q  <= raw_ext - prev_ext;
			kd_q  <= kd_next;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_next;
		end
		if (cmd.kp_load) begin
			kp_q <= kp_next;
		end
		if (cmd.acc_first) begin
			acc_q <= p_term + i_term;
		end else if (cmd.acc_second) begin
			acc_q <= acc_q + d_term;
		end
		if (cmd.duty_calc) begin
			duty_q <= duty_next;
			dir_q  <= dir_next;
		end
	end

	// Loop state kept across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			integral_q <= '0;
			run_q      <= '0;
		end else begin
			if (cmd.eval_err) begin
				prev_q <= raw_q;
			end
			if (cmd.int_upd) begin
				if (run_hit) begin
					integral_q <= '0;
					run_q      <= '0;
				end else begin
					integral_q <= int_clamped;
					run_q      <= err_zero ? run_inc : '0;
				end
			end
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			dir_out_q  <= dir_q;
			duty_out_q <= duty_q;
			ph_q       <= (dir_q == DIR_BRAKE) ? PH_W'(PULSE_HIGH_HOLD)
			                                   : PH_W'(PULSE_HIGH_DRIVE);
			pl_q       <= PL_W'(PULSE_LOW_BASE)
			            - PL_W'(duty_q) * PL_W'(PULSE_LOW_STEP);
			pulsing_q  <= dir_q != DIR_BRAKE;
		end
	end

	assign status.div_busy = div_busy;
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign direction     = dir_out_q;
	assign duty          = duty_out_q;
	assign pulse_high_ms = ph_q;
	assign pulse_low_ms  = pl_q;
	assign pulsing       = pulsing_q;

endmodule

>>> src/agtp_ctrl.sv
// ---------------------------------------------------------------------------
// agtp_ctrl: sequencing state machine
// Steps one item through error, multiplies, integral, gain wait, sum,
// duty and output load.
// ---------------------------------------------------------------------------
module agtp_ctrl import agtp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  agtp_status_t status,
	output agtp_cmd_t    cmd
);

	agtp_state_t state_q;
	agtp_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_next = ST_ERR;
			ST_ERR:   state_next = ST_MUL_I;
			ST_MUL_I: state_next = ST_INT;
			ST_INT:   state_next = ST_KP;
			ST_KP:    if (!status.div_busy) state_next = ST_MUL_P;
			ST_MUL_P: state_next = ST_ACC1;
			ST_ACC1:  state_next = ST_MUL_D;
			ST_MUL_D: state_next = ST_ACC2;
			ST_ACC2:  state_next = ST_DUTY;
			ST_DUTY:  state_next = ST_OUT;
			ST_OUT:   if (status.out_free) state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_ERR: cmd.eval_err = 1'b1;
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_KI;
			end
			ST_INT:  cmd.int_upd = 1'b1;
			ST_KP:   cmd.kp_load = !status.div_busy;
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR_KP;
			end
			ST_ACC1: cmd.acc_first = 1'b1;
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DR_KD;
			end
			ST_ACC2: cmd.acc_second = 1'b1;
			ST_DUTY: cmd.duty_calc = 1'b1;
			ST_OUT:  cmd.out_load = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule
